### design/mtms_pkg.sv
// Package for the momentum to magnet setpoint pipeline.
// Holds the fixed-point types, the coefficient and calibration constants and the
// rounding multiply and output saturation helpers. It depends on nothing.
`default_nettype none

package mtms_pkg;

  localparam int FRAC_BITS = 12;

  // Q30 working value, sized for the clamped magnet ranges
  typedef logic signed [37:0] q30_t;
  // momentum or polynomial argument in Q24
  typedef logic signed [31:0] q24_t;
  typedef logic signed [45:0] prod_t;
  typedef logic signed [15:0] volts_t;

  typedef struct packed {
    volts_t q1;
    volts_t q2;
    volts_t m1;
    volts_t q3;
    volts_t q4;
    volts_t m3;
  } fixed_volts_t;

  localparam longint Q30_ONE = 64'sd1073741824;
  localparam longint Q24_ONE = 64'sd16777216;

  // current limits
  localparam q30_t C_Q_LIM  = 38'((64'sd133 * Q30_ONE + 64'sd10 / 64'sd2) / 64'sd10);
  localparam q30_t C_M1_LIM = 38'((64'sd1465 * Q30_ONE + 64'sd100 / 64'sd2) / 64'sd100);
  localparam q30_t C_M2_LIM = 38'((64'sd1704 * Q30_ONE + 64'sd100 / 64'sd2) / 64'sd100);
  localparam q30_t C_M3_LIM = 38'(64'sd18 * Q30_ONE);

  // linear gains
  localparam q30_t C_Q2_K = 38'((64'sd144 * Q30_ONE + 64'sd100 / 64'sd2) / 64'sd100);
  localparam q30_t C_Q4_K = 38'((64'sd45 * Q30_ONE + 64'sd100 / 64'sd2) / 64'sd100);
  localparam q30_t C_M1_K = 38'((64'sd3457 * Q30_ONE + 64'sd1000 / 64'sd2) / 64'sd1000);

  // m2 cubic, highest order first
  localparam q30_t C_A3 =
    -38'((64'sd530077 * Q30_ONE + 64'sd10000000 / 64'sd2) / 64'sd10000000);
  localparam q30_t C_A2 =
    38'((64'sd254558 * Q30_ONE + 64'sd1000000 / 64'sd2) / 64'sd1000000);
  localparam q30_t C_A1 =
    -38'((64'sd419518 * Q30_ONE + 64'sd100000 / 64'sd2) / 64'sd100000);
  localparam q30_t C_A0 =
    38'((64'sd882209 * Q30_ONE + 64'sd10000000 / 64'sd2) / 64'sd10000000);

  // m3 cubic
  localparam q30_t C_B3 =
    38'((64'sd109945 * Q30_ONE + 64'sd10000000 / 64'sd2) / 64'sd10000000);
  localparam q30_t C_B2 =
    -38'((64'sd931518 * Q30_ONE + 64'sd10000000 / 64'sd2) / 64'sd10000000);
  localparam q30_t C_B1 =
    38'((64'sd237158 * Q30_ONE + 64'sd100000 / 64'sd2) / 64'sd100000);
  localparam q30_t C_B0 =
    -38'((64'sd247994 * Q30_ONE + 64'sd1000000 / 64'sd2) / 64'sd1000000);

  // m2 quintic map and final offset
  localparam q30_t C_D5 =
    38'((64'sd368299 * Q30_ONE + 64'sd100000000000 / 64'sd2) / 64'sd100000000000);
  localparam q30_t C_D4 =
    -38'((64'sd115031 * Q30_ONE + 64'sd1000000000 / 64'sd2) / 64'sd1000000000);
  localparam q30_t C_D3 =
    38'((64'sd134248 * Q30_ONE + 64'sd100000000 / 64'sd2) / 64'sd100000000);
  localparam q30_t C_D2 =
    -38'((64'sd680999 * Q30_ONE + 64'sd100000000 / 64'sd2) / 64'sd100000000);
  localparam q30_t C_D1 =
    38'((64'sd102905 * Q30_ONE + 64'sd1000000 / 64'sd2) / 64'sd1000000);
  localparam q30_t C_D0 =
    38'((64'sd119342 * Q30_ONE + 64'sd10000000 / 64'sd2) / 64'sd10000000);
  localparam q30_t C_E0 =
    -38'((64'sd594754 * Q30_ONE + 64'sd100000000 / 64'sd2) / 64'sd100000000);

  // calibration factors, Q24
  localparam q24_t F_Q1 = 32'((64'sd1 * Q24_ONE + 64'sd7 / 64'sd2) / 64'sd7);
  localparam q24_t F_Q  = 32'((64'sd5 * Q24_ONE + 64'sd16 / 64'sd2) / 64'sd16);
  localparam q24_t F_M1 =
    32'((64'sd558425 * Q24_ONE + 64'sd2181600 / 64'sd2) / 64'sd2181600);
  localparam q24_t F_M3 =
    32'((64'sd349015625 * Q24_ONE + 64'sd1363500000 / 64'sd2) / 64'sd1363500000);
  localparam q24_t F_M2 =
    32'((64'sd990426 * Q24_ONE + 64'sd1000000 / 64'sd2) / 64'sd1000000);

  // the cubics see momentum limited to 8 GeV/c
  localparam q24_t P_CAP = 32'(64'sd8 * Q24_ONE);

  localparam int     EMIT_SHIFT = 30 - FRAC_BITS;
  localparam longint EMIT_HALF  = 64'sd1 <<< (EMIT_SHIFT - 1);

  // Q30 times Q24, rounded half up back to Q30
  function automatic prod_t mulq(input q30_t a, input q24_t b);
    logic signed [69:0] prod;
    prod = 70'(a) * 70'(b);
    return 46'((prod + 70'sd8388608) >>> 24);
  endfunction

  function automatic q30_t clamp_hi(input prod_t v, input q30_t lim);
    return 38'((v > 46'(lim)) ? 46'(lim) : v);
  endfunction

  function automatic q30_t clamp_lo(input prod_t v, input q30_t lim);
    return 38'((v < -46'(lim)) ? -46'(lim) : v);
  endfunction

  // Q30 to output format, rounded half up and saturated
  function automatic volts_t emit(input q30_t v);
    logic signed [38:0] r;
    r = (39'(v) + 39'(EMIT_HALF)) >>> EMIT_SHIFT;
    if (r > 39'sd32767) begin
      return 16'sh7fff;
    end else if (r < -39'sd32768) begin
      return 16'sh8000;
    end else begin
      return 16'(r);
    end
  endfunction

endpackage

`default_nettype wire

### design/momentum_to_magnet_setpoints.sv
// Top level: momentum to seven magnet shunt voltage setpoints.
// Ten-stage pipeline: linear lanes, two Horner cubics, then the m2 quintic map.
// Throughput: one momentum per cycle unless out_ready stalls; each stage holds at most one multiply and add per lane.
// Stalls collapse bubbles: input is taken whenever any stage is empty or moving.
// Reset (rst, synchronous): clears the stage valid bits; datapath regs hold junk.
// Depends on mtms_pkg.
`default_nettype none

module momentum_to_magnet_setpoints (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire logic [14:0]          momentum,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      mtms_pkg::volts_t     quad_one_volts,
  output      mtms_pkg::volts_t     quad_two_volts,
  output      mtms_pkg::volts_t     dipole_one_volts,
  output      mtms_pkg::volts_t     quad_three_volts,
  output      mtms_pkg::volts_t     quad_four_volts,
  output      mtms_pkg::volts_t     dipole_two_volts,
  output      mtms_pkg::volts_t     dipole_three_volts
);
  import mtms_pkg::*;

  localparam int NSTAGE = 10;

  logic [NSTAGE:1] v;
  logic [NSTAGE:1] adv;

  // stage 1: linear lanes, first Horner step
  q30_t s1_q1, s1_q2, s1_q3, s1_q4, s1_m1, s1_a, s1_b;
  q24_t s1_pc;
  // stage 2: calibrated linear lanes, second Horner step
  q30_t s2_q1, s2_q2, s2_q3, s2_q4, s2_m1, s2_a, s2_b;
  q24_t s2_pc;
  // stage 3: cubics finished and clamped, linear lanes emitted
  fixed_volts_t s3_fix;
  q30_t s3_m2, s3_m3;
  // stages 4..8: quintic Horner on x
  fixed_volts_t s4_fix, s5_fix, s6_fix, s7_fix, s8_fix, s9_fix;
  q24_t s4_x, s5_x, s6_x, s7_x;
  q30_t s4_d, s5_d, s6_d, s7_d, s8_d;
  q30_t s4_m3;
  q30_t s9_m2;

  // next values
  q24_t p24, pc;
  prod_t q1w, q3w;
  q30_t nx_q1, nx_q2, nx_q3, nx_q4, nx_m1, nx_a1, nx_b1;
  logic signed [38:0] neg_m2;
  q24_t nx_x;

  always_comb begin
    adv[NSTAGE] = !v[NSTAGE] || out_ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k + 1];
    end
  end

  assign in_ready  = adv[1];
  assign out_valid = v[NSTAGE];

  always_comb begin
    p24   = 32'({momentum, {(24 - FRAC_BITS){1'b0}}});
    pc    = (p24 > P_CAP) ? P_CAP : p24;
    q1w   = -(46'(p24) <<< 7);
    q3w   = -(46'(p24) <<< 6);
    nx_q1 = clamp_lo(q1w, C_Q_LIM);
    nx_q3 = clamp_lo(q3w, C_Q_LIM);
    nx_q2 = clamp_hi(mulq(C_Q2_K, p24), C_Q_LIM);
    nx_q4 = clamp_hi(mulq(C_Q4_K, p24), C_Q_LIM);
    nx_m1 = clamp_hi(mulq(C_M1_K, p24), C_M1_LIM);
    nx_a1 = C_A2 + 38'(mulq(C_A3, pc));
    nx_b1 = C_B2 + 38'(mulq(C_B3, pc));
  end

  // x = -m2 taken to Q24 with rounding
  always_comb begin
    neg_m2 = -39'(s3_m2);
    nx_x   = 32'((neg_m2 + 39'sd32) >>> 6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= (adv & {v[NSTAGE-1:1], in_valid}) | (~adv & v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_q1 <= nx_q1;
      s1_q2 <= nx_q2;
      s1_q3 <= nx_q3;
      s1_q4 <= nx_q4;
      s1_m1 <= nx_m1;
      s1_a  <= nx_a1;
      s1_b  <= nx_b1;
      s1_pc <= pc;
    end
    if (adv[2]) begin
      s2_q1 <= 38'(-mulq(s1_q1, F_Q1));
      s2_q2 <= 38'(mulq(s1_q2, F_Q));
      s2_q3 <= 38'(-mulq(s1_q3, F_Q));
      s2_q4 <= 38'(mulq(s1_q4, F_Q));
      s2_m1 <= 38'(mulq(s1_m1, F_M1));
      s2_a  <= C_A1 + 38'(mulq(s1_a, s1_pc));
      s2_b  <= C_B1 + 38'(mulq(s1_b, s1_pc));
      s2_pc <= s1_pc;
    end
    if (adv[3]) begin
      s3_fix.q1 <= emit(s2_q1);
      s3_fix.q2 <= emit(s2_q2);
      s3_fix.m1 <= emit(s2_m1);
      s3_fix.q3 <= emit(s2_q3);
      s3_fix.q4 <= emit(s2_q4);
      s3_fix.m3 <= '0;
      s3_m2     <= clamp_lo(46'(C_A0) + mulq(s2_a, s2_pc), C_M2_LIM);
      s3_m3     <= clamp_hi(46'(C_B0) + mulq(s2_b, s2_pc), C_M3_LIM);
    end
    if (adv[4]) begin
      s4_fix <= s3_fix;
      s4_x   <= nx_x;
      s4_d   <= C_D4 + 38'(mulq(C_D5, nx_x));
      s4_m3  <= 38'(mulq(s3_m3, F_M3));
    end
    if (adv[5]) begin
      s5_fix <= '{q1: s4_fix.q1, q2: s4_fix.q2, m1: s4_fix.m1, q3: s4_fix.q3,
                  q4: s4_fix.q4, m3: emit(s4_m3)};
      s5_x   <= s4_x;
      s5_d   <= C_D3 + 38'(mulq(s4_d, s4_x));
    end
    if (adv[6]) begin
      s6_fix <= s5_fix;
      s6_x   <= s5_x;
      s6_d   <= C_D2 + 38'(mulq(s5_d, s5_x));
    end
    if (adv[7]) begin
      s7_fix <= s6_fix;
      s7_x   <= s6_x;
      s7_d   <= C_D1 + 38'(mulq(s6_d, s6_x));
    end
    if (adv[8]) begin
      s8_fix <= s7_fix;
      s8_d   <= C_D0 + 38'(mulq(s7_d, s7_x));
    end
    if (adv[9]) begin
      s9_fix <= s8_fix;
      s9_m2  <= C_E0 + 38'(mulq(s8_d, F_M2));
    end
    if (adv[10]) begin
      quad_one_volts     <= s9_fix.q1;
      quad_two_volts     <= s9_fix.q2;
      dipole_one_volts   <= s9_fix.m1;
      quad_three_volts   <= s9_fix.q3;
      quad_four_volts    <= s9_fix.q4;
      dipole_two_volts   <= emit(s9_m2);
      dipole_three_volts <= s9_fix.m3;
    end
  end

  // any empty stage lets a new beat in
  a_bubble_accepts: assert property (@(posedge clk) disable iff (rst)
    !(&v) |-> in_ready)
    else $error("input stalled while a pipeline stage is empty");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !(out_valid && out_ready))
    |=> $countones(v) == $past($countones(v)) + 1)
    else $error("accepted beat not tracked in pipeline");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!(in_valid && in_ready) && out_valid && out_ready)
    |=> $countones(v) == $past($countones(v)) - 1)
    else $error("delivered beat not removed from pipeline");

  // clamped m2 keeps the quintic argument inside its working range
  a_x_range: assert property (@(posedge clk) disable iff (rst)
    v[4] |-> (s4_x >= -32'sd4194304 && s4_x <= 32'sd286000000))
    else $error("quintic argument out of range");

endmodule

`default_nettype wire
